>>> hdl/hmap_pkg.sv
// Package with the shared types and constants of the chained hash map.
package hmap_pkg;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 31;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;
    localparam int CNT_W     = 5;
    localparam int MOD_STEPS = 8;
    localparam int MOD_BITS  = 4;
    localparam int MOD_CW    = $clog2(MOD_STEPS);

    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = 5'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            capture;
        logic            mod_step;
        logic            alloc;
        logic            put_write;
        logic            walk_start;
        logic            walk_read;
        logic            advance;
        logic            unlink;
        logic            finish;
        logic [ST_W-1:0] st;
        logic            take_value;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic            mod_done;
        logic [OP_W-1:0] op;
        logic            cur_nil;
        logic            key_match;
        logic            pool_full;
    } stat_t;

endpackage

>>> hdl/hmap_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/hmap_ctrl.sv
// Controller state machine that sequences each put, get and remove.
module hmap_ctrl import hmap_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MOD      = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_PUT_WR   = 3'd3;
    localparam logic [2:0] S_WALK_RD  = 3'd4;
    localparam logic [2:0] S_WALK_CMP = 3'd5;
    localparam logic [2:0] S_FIN      = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [ST_W-1:0] st_reg, st_next;
    logic            take_reg, take_next;
    logic            out_valid_reg, out_valid_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        take_next  = take_reg;
        cmd        = '0;
        cmd.st         = st_reg;
        cmd.take_value = take_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_done)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                take_next = 1'b0;
                case (stat.op) inside
                    OP_PUT:
                    begin
                        if (stat.pool_full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.alloc  = 1'b1;
                            state_next = S_PUT_WR;
                        end
                    end
                    OP_GET, OP_REMOVE:
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = S_WALK_RD;
                    end
                    default:
                    begin
                        st_next    = ST_OK;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_PUT_WR:
            begin
                cmd.put_write = 1'b1;
                st_next       = ST_OK;
                state_next    = S_FIN;
            end
            S_WALK_RD:
            begin
                if (stat.cur_nil)
                begin
                    st_next    = ST_MISS;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.walk_read = 1'b1;
                    state_next    = S_WALK_CMP;
                end
            end
            S_WALK_CMP:
            begin
                if (stat.key_match)
                begin
                    cmd.unlink = (stat.op == OP_REMOVE);
                    take_next  = (stat.op == OP_GET);
                    st_next    = ST_OK;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_WALK_RD;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            st_reg        <= ST_OK;
            take_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            take_reg      <= take_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hdl/hmap_dp.sv
// Datapath: modulo unit, bucket heads, node memories and free-node stack.
module hmap_dp import hmap_pkg::*; #(
    parameter int BUCKETS = 16,
    parameter int NODES   = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output stat_t            stat,
    input  logic [OP_W-1:0]  operation,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] value,
    input  logic             cfg_valid,
    input  logic [CNT_W-1:0] bucket_count,
    output logic [ST_W-1:0]  status,
    output logic [VAL_W-1:0] read_value
);

    localparam int PW  = $clog2(NODES + 1);
    localparam int AW  = $clog2(NODES);
    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int KVW = KEY_W + VAL_W;
    localparam int SHW = MOD_STEPS * MOD_BITS;
    localparam logic [PW-1:0] NIL = PW'(NODES);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SHW-1:0]    shift_reg;
    logic [MOD_CW-1:0] step_reg;
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [PW-1:0]     head_reg [BUCKETS];
    logic [PW-1:0]     cur_reg, prev_reg;
    logic [PW-1:0]     sp_reg, hwm_reg, alloc_reg;
    logic              use_stack_reg;
    logic [ST_W-1:0]   status_reg;
    logic [VAL_W-1:0]  read_value_reg;
    logic [BW-1:0]     bucket;
    logic [PW-1:0]     node;
    logic [PW-1:0]     head_cur;

    logic [KVW-1:0]    kv_rdata;
    logic [PW-1:0]     next_rdata;
    logic [PW-1:0]     stack_rdata;
    logic              next_we;
    logic [AW-1:0]     next_waddr;
    logic [PW-1:0]     next_wdata;
    logic              push;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= BUCKET_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            count_reg <= bucket_count;
        end
    end

    // Clamp the bucket count to the range in use.
    always_comb
    begin
        if (count_reg == '0)
        begin
            div_next = CNT_W'(1);
        end
        else if (32'(count_reg) > BUCKETS)
        begin
            div_next = CNT_W'(BUCKETS);
        end
        else
        begin
            div_next = count_reg;
        end
    end

    // Restoring remainder, several key bits per cycle.
    always_comb
    begin
        logic [CNT_W:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < MOD_BITS; i++)
        begin
            r = {r[CNT_W-1:0], shift_reg[SHW-1-i]};
            if (r >= {1'b0, div_reg})
            begin
                r = r - {1'b0, div_reg};
            end
        end
        rem_next = r[CNT_W-1:0];
    end

    // Captured item and modulo state.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            key_reg   <= key;
            val_reg   <= value;
            div_reg   <= div_next;
            rem_reg   <= '0;
            shift_reg <= SHW'(key);
        end
        else if (cmd.mod_step)
        begin
            rem_reg   <= rem_next;
            shift_reg <= shift_reg << MOD_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.capture)
        begin
            step_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            step_reg <= step_reg + MOD_CW'(1);
        end
    end

    assign bucket   = BW'(rem_reg);
    assign head_cur = head_reg[bucket];
    assign node     = use_stack_reg ? stack_rdata : alloc_reg;

    // Bucket heads, all null after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
            begin
                head_reg[i] <= NIL;
            end
        end
        else if (cmd.put_write)
        begin
            head_reg[bucket] <= node;
        end
        else if (cmd.unlink && (prev_reg == NIL))
        begin
            head_reg[bucket] <= next_rdata;
        end
    end

    // Free-node pool: the stack of freed nodes first, then unused nodes from the high-water mark up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= '0;
            hwm_reg <= '0;
        end
        else if (cmd.alloc)
        begin
            if (sp_reg != '0)
            begin
                sp_reg <= sp_reg - PW'(1);
            end
            else
            begin
                hwm_reg <= hwm_reg + PW'(1);
            end
        end
        else if (push)
        begin
            sp_reg <= sp_reg + PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            use_stack_reg <= (sp_reg != '0);
            alloc_reg     <= hwm_reg;
        end
    end

    // Chain walk pointers.
    always_ff @(posedge clk)
    begin
        if (cmd.walk_start)
        begin
            cur_reg  <= head_cur;
            prev_reg <= NIL;
        end
        else if (cmd.advance)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= next_rdata;
        end
    end

    // Next-pointer writes come from a put or from an unlink.
    assign push       = cmd.unlink;
    assign next_we    = cmd.put_write || (cmd.unlink && (prev_reg != NIL));
    assign next_waddr = cmd.put_write ? node[AW-1:0] : prev_reg[AW-1:0];
    assign next_wdata = cmd.put_write ? head_cur : next_rdata;

    hmap_ram #(.WIDTH(KVW), .DEPTH(NODES)) u_kv_ram (
        .clk   (clk),
        .we    (cmd.put_write),
        .waddr (node[AW-1:0]),
        .wdata ({key_reg, val_reg}),
        .re    (cmd.walk_read),
        .raddr (cur_reg[AW-1:0]),
        .rdata (kv_rdata)
    );

    hmap_ram #(.WIDTH(PW), .DEPTH(NODES)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (cmd.walk_read),
        .raddr (cur_reg[AW-1:0]),
        .rdata (next_rdata)
    );

    hmap_ram #(.WIDTH(PW), .DEPTH(NODES)) u_stack_ram (
        .clk   (clk),
        .we    (push),
        .waddr (sp_reg[AW-1:0]),
        .wdata (cur_reg),
        .re    (cmd.alloc),
        .raddr (AW'(sp_reg - PW'(1))),
        .rdata (stack_rdata)
    );

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg     <= cmd.st;
            read_value_reg <= cmd.take_value ? kv_rdata[VAL_W-1:0] : '0;
        end
    end

    assign status     = status_reg;
    assign read_value = read_value_reg;

    // Status back to the controller.
    always_comb
    begin
        stat.mod_done  = (step_reg == MOD_CW'(MOD_STEPS - 1));
        stat.op        = op_reg;
        stat.cur_nil   = (cur_reg == NIL);
        stat.key_match = (kv_rdata[KVW-1:VAL_W] == key_reg);
        stat.pool_full = (sp_reg == '0) && (hwm_reg == NIL);
    end

endmodule

>>> hdl/chained_hash_map_core.sv
// Top level of the chained hash map: controller and datapath.
//
//  Channel | Signals                             | Direction
//  --------+-------------------------------------+----------
//  input   | in_valid, in_ready, operation, key, | in
//          | value                               |
//  output  | out_valid, out_ready, status,       | out
//          | read_value                          |
//  config  | cfg_valid, cfg_ready, bucket_count  | in
//
// One item at a time. Each item is captured and its key runs through the remainder
// unit (four key bits per cycle); then a put writes its node and finishes, a rejected
// put or an unused operation code goes straight to finish, and a get or remove reads
// and compares each chain node in turn (registered node reads) until a match or the end.
// Reset empties every bucket and frees the whole pool at once; no clearing pass.
// A result word waiting on out_ready holds the next item in its last state only.
module chained_hash_map_core import hmap_pkg::*; #(
    parameter int BUCKETS = 16,
    parameter int NODES   = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [OP_W-1:0]  operation,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ST_W-1:0]  status,
    output logic [VAL_W-1:0] read_value,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] bucket_count
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    hmap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hmap_dp #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (operation),
        .key          (key),
        .value        (value),
        .cfg_valid    (cfg_valid),
        .bucket_count (bucket_count),
        .status       (status),
        .read_value   (read_value)
    );

endmodule

>>> hdl/hmap_checker.sv
// Port-level checker for the chained hash map and its bind.
module hmap_checker import hmap_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [ST_W-1:0]  status,
    input logic [VAL_W-1:0] read_value
);

    // A waiting result word holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_value))
        else $error("result word changed while stalled");

    // Only the three status codes are produced.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_MISS || status == ST_FULL))
        else $error("undefined status code");

    // A value is returned only with a success status.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> read_value == '0)
        else $error("nonzero value with failure status");

    // An accepted word closes the input until its work is done.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

endmodule

bind chained_hash_map_core hmap_checker u_hmap_checker (.*);
